// ===== src/tshc_pkg.sv =====
// Shared types, widths and codes for the tilt seek hill-climb block.
// Used by every module in src; depends on nothing else.
package tshc_pkg;

  // Reading width; thresholds are fixed at 16 bits.
  localparam int SAMPLE_BITS = 16;
  localparam int THR_BITS    = 16;
  localparam int CMP_W       = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int STEP_W      = 10;
  localparam int READS_W     = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FAST_BELOW   = 3'd0,
    REG_MEDIUM_BELOW = 3'd1,
    REG_FAST_STEPS   = 3'd2,
    REG_MEDIUM_STEPS = 3'd3,
    REG_SLOW_STEPS   = 3'd4,
    REG_PROBE_STEPS  = 3'd5,
    REG_COARSE_READS = 3'd6,
    REG_FINE_READS   = 3'd7
  } cfg_idx_t;

  // Reported search status.
  typedef enum logic [1:0] {
    ST_SEARCH  = 2'd0,
    ST_ALIGNED = 2'd1,
    ST_GAVE_UP = 2'd2
  } status_t;

  // Search phases, one-hot.
  typedef enum logic [6:0] {
    PH_PROBE   = 7'b0000001,
    PH_JUDGE   = 7'b0000010,
    PH_REVERSE = 7'b0000100,
    PH_CRUISE  = 7'b0001000,
    PH_INCH    = 7'b0010000,
    PH_FINISH  = 7'b0100000,
    PH_ENDED   = 7'b1000000
  } phase_t;

  // Configuration register contents.
  typedef struct packed {
    logic signed [THR_BITS-1:0] fast_below;
    logic signed [THR_BITS-1:0] medium_below;
    logic [STEP_W-1:0]          fast_steps;
    logic [STEP_W-1:0]          medium_steps;
    logic [STEP_W-1:0]          slow_steps;
    logic [STEP_W-1:0]          probe_steps;
    logic [READS_W-1:0]         coarse_reads;
    logic [READS_W-1:0]         fine_reads;
  } cfg_t;

  // Move command; step_count sits in the lowest bits.
  typedef struct packed {
    status_t            status;
    logic [READS_W-1:0] reads_next;
    logic               microstep;
    logic               backward;
    logic [STEP_W-1:0]  step_count;
  } res_t;

  localparam int RES_W       = $bits(res_t);
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== src/tshc_cfg.sv =====
// Configuration register file for the tilt seek hill-climb block.
// Depends on tshc_pkg.
module tshc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tshc_pkg::CFG_ADDR_W-1:0] wr_addr,
  input  logic [tshc_pkg::CFG_DATA_W-1:0] wr_data,
  output tshc_pkg::cfg_t                 cfg
);
  import tshc_pkg::*;

  cfg_t cfg_r;

  // Registers take their documented values at reset and one write per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_below   <= 16'sd1280;
      cfg_r.medium_below <= 16'sd2304;
      cfg_r.fast_steps   <= STEP_W'(500);
      cfg_r.medium_steps <= STEP_W'(200);
      cfg_r.slow_steps   <= STEP_W'(100);
      cfg_r.probe_steps  <= STEP_W'(200);
      cfg_r.coarse_reads <= READS_W'(3);
      cfg_r.fine_reads   <= READS_W'(50);
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_addr))
        REG_FAST_BELOW:   cfg_r.fast_below   <= signed'(wr_data[THR_BITS-1:0]);
        REG_MEDIUM_BELOW: cfg_r.medium_below <= signed'(wr_data[THR_BITS-1:0]);
        REG_FAST_STEPS:   cfg_r.fast_steps   <= wr_data[STEP_W-1:0];
        REG_MEDIUM_STEPS: cfg_r.medium_steps <= wr_data[STEP_W-1:0];
        REG_SLOW_STEPS:   cfg_r.slow_steps   <= wr_data[STEP_W-1:0];
        REG_PROBE_STEPS:  cfg_r.probe_steps  <= wr_data[STEP_W-1:0];
        REG_COARSE_READS: cfg_r.coarse_reads <= wr_data[READS_W-1:0];
        REG_FINE_READS:   cfg_r.fine_reads   <= wr_data[READS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tshc_climb.sv =====
// Hill-climb decision logic and search state for the tilt seek block.
// Works out one move command per reading; depends on tshc_pkg.
module tshc_climb (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  logic signed [tshc_pkg::SAMPLE_BITS-1:0] sample,
  input  tshc_pkg::cfg_t                        cfg,
  output tshc_pkg::res_t                        res
);
  import tshc_pkg::*;

  phase_t                        phase_r, phase_nxt;
  logic                          second_probe_r, second_probe_nxt;
  logic                          dir_back_r, dir_back_nxt;
  logic                          fine_mode_r, fine_mode_nxt;
  logic signed [SAMPLE_BITS-1:0] last_r, last_nxt;
  logic signed [SAMPLE_BITS-1:0] older_r, older_nxt;
  status_t                       end_status_r, end_status_nxt;

  logic signed [CMP_W-1:0] rd_x;
  logic signed [CMP_W-1:0] fast_x;
  logic signed [CMP_W-1:0] medium_x;
  logic [STEP_W-1:0]       cruise;
  logic [STEP_W-1:0]       steps;
  logic [READS_W-1:0]      reads;
  logic                    rise;

  // Cruise speed is picked from the reading against the two thresholds.
  always_comb begin
    rd_x     = CMP_W'(sample);
    fast_x   = CMP_W'(cfg.fast_below);
    medium_x = CMP_W'(cfg.medium_below);
    if (rd_x < fast_x) begin
      cruise = cfg.fast_steps;
    end else if (rd_x < medium_x) begin
      cruise = cfg.medium_steps;
    end else begin
      cruise = cfg.slow_steps;
    end
  end

  assign rise = sample > last_r;

  // Phase sequencing and the move for this reading.
  always_comb begin
    phase_nxt        = phase_r;
    second_probe_nxt = second_probe_r;
    dir_back_nxt     = dir_back_r;
    fine_mode_nxt    = fine_mode_r;
    last_nxt         = last_r;
    older_nxt        = older_r;
    end_status_nxt   = end_status_r;
    steps            = '0;
    case (phase_r)
      PH_PROBE: begin
        last_nxt  = sample;
        steps     = cfg.probe_steps;
        phase_nxt = PH_JUDGE;
      end
      PH_JUDGE: begin
        if (rise) begin
          phase_nxt = PH_CRUISE;
          steps     = cruise;
        end else begin
          phase_nxt        = PH_REVERSE;
          dir_back_nxt     = 1'b1;
          steps            = cfg.probe_steps;
          second_probe_nxt = 1'b1;
        end
        older_nxt = last_r;
        last_nxt  = sample;
      end
      PH_REVERSE: begin
        if (second_probe_r) begin
          steps            = cfg.probe_steps;
          second_probe_nxt = 1'b0;
        end else if (rise && (last_r > older_r)) begin
          phase_nxt = PH_CRUISE;
          steps     = cruise;
        end else if ((last_r > sample) && (last_r > older_r)) begin
          phase_nxt    = PH_INCH;
          dir_back_nxt = 1'b0;
          steps        = STEP_W'(1);
        end else begin
          phase_nxt      = PH_ENDED;
          end_status_nxt = ST_GAVE_UP;
        end
        older_nxt = last_r;
        last_nxt  = sample;
      end
      PH_CRUISE: begin
        if (rise) begin
          steps = cruise;
        end else begin
          dir_back_nxt  = !dir_back_r;
          steps         = STEP_W'(1);
          phase_nxt     = PH_INCH;
          fine_mode_nxt = 1'b1;
        end
        older_nxt = last_r;
        last_nxt  = sample;
      end
      PH_INCH: begin
        // The stored reading is held while inching.
        if (!rise) begin
          dir_back_nxt = !dir_back_r;
          phase_nxt    = PH_FINISH;
        end
        steps = STEP_W'(1);
      end
      PH_FINISH: begin
        phase_nxt      = PH_ENDED;
        end_status_nxt = ST_ALIGNED;
      end
      default: ;
    endcase

    // Reads count follows the mode after this reading; zero reads as one.
    reads = fine_mode_nxt ? cfg.fine_reads : cfg.coarse_reads;
    if (reads == '0) begin
      reads = READS_W'(1);
    end

    res.step_count = steps;
    res.backward   = dir_back_nxt;
    res.microstep  = fine_mode_nxt;
    res.reads_next = reads;
    res.status     = end_status_nxt;
  end

  // State advances once per reading taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_PROBE;
      second_probe_r <= 1'b0;
      dir_back_r     <= 1'b0;
      fine_mode_r    <= 1'b0;
      last_r         <= '0;
      older_r        <= '0;
      end_status_r   <= ST_SEARCH;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      second_probe_r <= second_probe_nxt;
      dir_back_r     <= dir_back_nxt;
      fine_mode_r    <= fine_mode_nxt;
      last_r         <= last_nxt;
      older_r        <= older_nxt;
      end_status_r   <= end_status_nxt;
    end
  end

endmodule

// ===== src/tilt_seek_hill_climb_top.sv =====
// Top level of the tilt seek hill-climb block: input register, decision
// logic and output register. Depends on tshc_pkg, tshc_cfg and tshc_climb.
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: accel_sample
//  out_    | master    | out_tvalid/out_tready| out_tdata: move command
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_addr, cfg_data
//
// One reading is taken per cycle unless out_ stalls; the reading is held in the
// input register, and its command is offered from the output register.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// search to the first probe; configuration takes its default values.
// A stall on out_ holds the command and fills the input register, after
// which in_tready falls. cfg_ready is always high.
module tilt_seek_hill_climb_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] accel_sample
  input  logic [tshc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [9:0] step_count, [10] backward, [11] microstep, [19:12] reads_next,
  // [21:20] status, rest zero
  output logic [tshc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tshc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tshc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tshc_pkg::*;

  cfg_t                          cfg;
  res_t                          res;
  res_t                          out_res_r;
  logic                          out_valid_r;
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          advance;

  assign cfg_ready = 1'b1;

  tshc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // A held reading moves on when the output register is free or emptying.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= signed'(in_tdata[SAMPLE_BITS-1:0]);
    end
  end

  tshc_climb u_climb (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

endmodule

// ===== src/tshc_checker.sv =====
// Port-level checks for the tilt seek hill-climb top level, bound to it.
// Depends on tshc_pkg and tilt_seek_hill_climb_top.
module tshc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tshc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tshc_pkg::*;

  res_t r;
  assign r = res_t'(out_tdata[RES_W-1:0]);

  // A stalled command beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("command changed while stalled");

  // With the output register empty, the block always takes a reading.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Once the search has ended, no steps are commanded.
  a_end_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (r.status != ST_SEARCH) |-> (r.step_count == '0))
    else $error("steps commanded after the end of the search");

  // Microstepping while searching is only ever single-step inching.
  a_inch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.microstep && (r.status == ST_SEARCH) |-> (r.step_count == STEP_W'(1)))
    else $error("microstep move of more than one step");

  // At least one sample is always requested for the next reading.
  a_reads: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (r.reads_next != '0))
    else $error("zero reads requested");

endmodule

bind tilt_seek_hill_climb_top tshc_checker u_tshc_checker (.*);
